/* hdl/cct_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared item types, calendar limits and the month-length and leap-year
// helpers used by the clock-calendar datapath and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  // Operation codes carried in the op field of an input item.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Calendar limits.
  localparam logic [13:0] YEAR_MIN   = 14'd2000;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;
  localparam logic [4:0]  HOUR_NOON  = 5'd12;
  localparam logic [3:0]  HOUR_TWELVE = 4'd12;

  // Reciprocal of 100 scaled by 2^19; exact floor division for any 14-bit year.
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;

  // One input item.
  typedef struct packed {
    logic        op;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [13:0] load_year;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
  } cct_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [13:0] cur_year;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [3:0]  hour_twelve;
    logic        is_pm;
  } cct_result_t;

  // Running date and time held by the block.
  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cct_time_t;

  // Gregorian leap test: divisible by 4, and not by 100 unless by 400.
  // The year is split by 100 with a reciprocal multiply; the quotient's low
  // two bits then give the test by 400.
  function automatic logic cct_is_leap(logic [13:0] year);
    logic [26:0] prod;
    logic [7:0]  quot;
    logic [13:0] quot_x100;
    logic        by_100;
    prod      = 27'(year) * 27'(RECIP_100);
    quot      = prod[RECIP_SHIFT +: 8];
    quot_x100 = 14'({quot, 6'b0}) + 14'({quot, 5'b0}) + 14'({quot, 2'b0});
    by_100    = (year == quot_x100);
    return (year[1:0] == 2'b00) && (!by_100 || (quot[1:0] == 2'b00));
  endfunction

  // Days in a month; an out-of-range month counts as 31 days.
  function automatic logic [4:0] cct_days_in(logic [3:0] month, logic leap);
    logic [4:0] days;
    case (month)
      4'd2:    days = leap ? 5'd29 : 5'd28;
      4'd4:    days = 5'd30;
      4'd6:    days = 5'd30;
      4'd9:    days = 5'd30;
      4'd11:   days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

/* hdl/cct_in_if.sv */
// ----------------------------------------------------------------------------
// Calendar clock input channel
// Valid/ready channel that carries one tick or load item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_in_if
  import cct_pkg::*;
();

  logic      valid;
  logic      ready;
  cct_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* hdl/cct_out_if.sv */
// ----------------------------------------------------------------------------
// Calendar clock result channel
// Valid/ready channel that carries one date and time result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cct_out_if
  import cct_pkg::*;
();

  logic        valid;
  logic        ready;
  cct_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* hdl/cct_step.sv */
// ----------------------------------------------------------------------------
// Calendar clock step
// Combinational next-state logic: applies one tick or one validated load to
// the running date and time and forms the result item, 12-hour view included.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_step
  import cct_pkg::*;
(
  input  cct_time_t   state_i,
  input  cct_item_t   item_i,
  output cct_result_t result_o
);

  cct_time_t   tick_time;
  cct_time_t   load_time;
  cct_time_t   next_time;
  logic        cur_leap;
  logic        load_leap;
  logic [3:0]  load_month;
  logic [13:0] load_year;

  // Tick: one second with the carry rippling up to the year.
  always_comb begin
    cur_leap  = cct_is_leap(state_i.year);
    tick_time = state_i;
    if (state_i.second < MINSEC_MAX) begin
      tick_time.second = state_i.second + 6'd1;
    end else begin
      tick_time.second = '0;
      if (state_i.minute < MINSEC_MAX) begin
        tick_time.minute = state_i.minute + 6'd1;
      end else begin
        tick_time.minute = '0;
        if (state_i.hour < HOUR_MAX) begin
          tick_time.hour = state_i.hour + 5'd1;
        end else begin
          tick_time.hour = '0;
          if (state_i.day >= cct_days_in(state_i.month, cur_leap)) begin
            tick_time.day = 5'd1;
            if (state_i.month >= MONTH_MAX) begin
              tick_time.month = 4'd1;
              if (state_i.year < YEAR_MAX) begin
                tick_time.year = state_i.year + 14'd1;
              end
            end else begin
              tick_time.month = state_i.month + 4'd1;
            end
          end else begin
            tick_time.day = state_i.day + 5'd1;
          end
        end
      end
    end
  end

  // Load: each field is checked; the day is checked against the loaded
  // month in the clamped year.
  always_comb begin
    load_month = ((item_i.load_month >= 4'd1) && (item_i.load_month <= MONTH_MAX)) ?
                 item_i.load_month : 4'd1;
    if (item_i.load_year < YEAR_MIN) begin
      load_year = YEAR_MIN;
    end else if (item_i.load_year > YEAR_MAX) begin
      load_year = YEAR_MAX;
    end else begin
      load_year = item_i.load_year;
    end
    load_leap        = cct_is_leap(load_year);
    load_time.month  = load_month;
    load_time.year   = load_year;
    load_time.day    = ((item_i.load_day >= 5'd1) &&
                        (item_i.load_day <= cct_days_in(load_month, load_leap))) ?
                       item_i.load_day : 5'd1;
    load_time.hour   = (item_i.load_hour <= HOUR_MAX) ? item_i.load_hour : '0;
    load_time.minute = (item_i.load_minute <= MINSEC_MAX) ? item_i.load_minute : '0;
    load_time.second = (item_i.load_second <= MINSEC_MAX) ? item_i.load_second : '0;
  end

  // Result: new time plus the 12-hour view.
  always_comb begin
    next_time            = (item_i.op == OP_LOAD) ? load_time : tick_time;
    result_o.cur_month   = next_time.month;
    result_o.cur_day     = next_time.day;
    result_o.cur_year    = next_time.year;
    result_o.cur_hour    = next_time.hour;
    result_o.cur_minute  = next_time.minute;
    result_o.cur_second  = next_time.second;
    result_o.is_pm       = (next_time.hour >= HOUR_NOON);
    if ((next_time.hour == '0) || (next_time.hour == HOUR_NOON)) begin
      result_o.hour_twelve = HOUR_TWELVE;
    end else if (next_time.hour > HOUR_NOON) begin
      result_o.hour_twelve = 4'(next_time.hour - HOUR_NOON);
    end else begin
      result_o.hour_twelve = next_time.hour[3:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/calendar_clock_tick.sv */
// ----------------------------------------------------------------------------
// Calendar clock tick
// Gregorian clock-calendar. A tick item advances the time by one second, a
// load item sets a validated date and time; each item returns one result.
//
//   Channel | Direction | Handshake   | Payload
//   in_i    | sink      | valid/ready | op, load_month .. load_second
//   out_o   | source    | valid/ready | cur_month .. cur_second, hour_twelve, is_pm
//
// One item per cycle is sustained while out_o is ready; an accepted item
// passes through the input register, then the result register.
// The time registers feed the combinational step logic, so each item sees the
// time left by the one before it with no gap.
// Reset sets the time to 00:00:00 on 1 January 2000 and empties both stages.
// A stall on out_o holds the result; the input register still takes one more
// item before in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_tick
  import cct_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  cct_in_if.sink    in_i,
  cct_out_if.source out_o
);

  logic        s1_valid_q;
  logic        s1_valid_d;
  cct_item_t   s1_item_q;
  logic        out_valid_q;
  logic        out_valid_d;
  cct_result_t out_q;
  cct_time_t   time_q;
  cct_time_t   time_d;
  cct_result_t step_result;
  logic        in_take;
  logic        s1_adv;

  // Handshake control.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Next-state logic for the registered item.
  cct_step u_step (
    .state_i  (time_q),
    .item_i   (s1_item_q),
    .result_o (step_result)
  );

  // Time advances when the item moves into the result register.
  always_comb begin
    time_d = time_q;
    if (s1_adv) begin
      time_d.month  = step_result.cur_month;
      time_d.day    = step_result.cur_day;
      time_d.year   = step_result.cur_year;
      time_d.hour   = step_result.cur_hour;
      time_d.minute = step_result.cur_minute;
      time_d.second = step_result.cur_second;
    end
  end

  // Control and time registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      time_q.month  <= 4'd1;
      time_q.day    <= 5'd1;
      time_q.year   <= YEAR_MIN;
      time_q.hour   <= '0;
      time_q.minute <= '0;
      time_q.second <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      time_q      <= time_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_i.data;
    end
    if (s1_adv) begin
      out_q <= step_result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // The running date always holds each field within the calendar limits.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.month >= 4'd1) && (time_q.month <= MONTH_MAX) &&
    (time_q.day >= 5'd1) && (time_q.day <= 5'd31) &&
    (time_q.year >= YEAR_MIN) && (time_q.year <= YEAR_MAX))
    else $error("date register out of range");

  // The running time always holds a legal clock value.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.hour <= HOUR_MAX) && (time_q.minute <= MINSEC_MAX) &&
    (time_q.second <= MINSEC_MAX))
    else $error("time register out of range");

  // A tick with no carry out of the seconds adds exactly one second.
  a_tick_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_item_q.op == OP_TICK) && (time_q.second < MINSEC_MAX) |=>
    (time_q.second == $past(time_q.second) + 6'd1) &&
    (time_q.minute == $past(time_q.minute)))
    else $error("tick did not advance the second");

  // The result register and the time registers are updated together.
  a_result_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && (out_q.cur_second == time_q.second) &&
    (out_q.cur_day == time_q.day) && (out_q.cur_year == time_q.year))
    else $error("result differs from the stored time");
`endif

endmodule

`default_nettype wire

/* bench/tb_calendar_clock_tick.sv */
// ----------------------------------------------------------------------------
// Calendar clock tick testbench
// Drives tick and load items into the clock-calendar with random gaps on both
// channels. A date and time tracker mirrors the Gregorian clock, queues the
// date it expects for every accepted item and compares each result field by
// field. Directed items cover clamping, leap days and the year limit; random
// items mostly load a time just short of a rollover and then tick across it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_clock_tick;
  import cct_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned CALM_PERIOD  = 50;

  // Mirror of the clock-calendar; holds the running time and the dates still
  // owed by the block.
  class date_time_tracker;
    cct_time_t   now;
    cct_result_t owed_dates[$];
    int unsigned mismatches;
    int unsigned loads;
    int unsigned ticks;
    int unsigned fixed_loads;
    int unsigned month_rolls;
    int unsigned year_rolls;
    int unsigned year_holds;
    int unsigned leap_days;

    function new();
      now.month  = 4'd1;
      now.day    = 5'd1;
      now.year   = YEAR_MIN;
      now.hour   = '0;
      now.minute = '0;
      now.second = '0;
    endfunction

    static function bit is_leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_length(int unsigned m, int unsigned y);
      case (m)
        2:       return is_leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    // Carry from the hour into the date.
    function void next_day();
      if (now.day >= month_length(now.month, now.year)) begin
        now.day = 5'd1;
        month_rolls++;
        if (now.month >= MONTH_MAX) begin
          now.month = 4'd1;
          if (now.year < YEAR_MAX) begin
            now.year = now.year + 14'd1;
            year_rolls++;
          end else begin
            year_holds++;
          end
        end else begin
          now.month = now.month + 4'd1;
        end
      end else begin
        now.day = now.day + 5'd1;
        if (now.month == 4'd2 && now.day == 5'd29) leap_days++;
      end
    endfunction

    // One second forward with the carry rippling up.
    function void next_second();
      if (now.second < MINSEC_MAX) begin
        now.second = now.second + 6'd1;
        return;
      end
      now.second = '0;
      if (now.minute < MINSEC_MAX) begin
        now.minute = now.minute + 6'd1;
        return;
      end
      now.minute = '0;
      if (now.hour < HOUR_MAX) begin
        now.hour = now.hour + 5'd1;
        return;
      end
      now.hour = '0;
      next_day();
    endfunction

    // Load with each out-of-range field replaced; the day is judged against
    // the loaded month in the clamped year.
    function void set_time(cct_item_t it);
      int unsigned y;
      int unsigned m;
      bit          fixed;
      fixed = 1'b0;
      m = it.load_month;
      if (m < 1 || m > MONTH_MAX) begin
        m = 1;
        fixed = 1'b1;
      end
      y = it.load_year;
      if (y < YEAR_MIN) begin
        y = YEAR_MIN;
        fixed = 1'b1;
      end
      if (y > YEAR_MAX) begin
        y = YEAR_MAX;
        fixed = 1'b1;
      end
      now.month = 4'(m);
      now.year  = 14'(y);
      if (it.load_day >= 1 && it.load_day <= month_length(m, y)) begin
        now.day = it.load_day;
      end else begin
        now.day = 5'd1;
        fixed = 1'b1;
      end
      now.hour   = (it.load_hour <= HOUR_MAX) ? it.load_hour : 5'd0;
      now.minute = (it.load_minute <= MINSEC_MAX) ? it.load_minute : 6'd0;
      now.second = (it.load_second <= MINSEC_MAX) ? it.load_second : 6'd0;
      if (it.load_hour > HOUR_MAX || it.load_minute > MINSEC_MAX ||
          it.load_second > MINSEC_MAX) fixed = 1'b1;
      if (fixed) fixed_loads++;
    endfunction

    // Apply an accepted item and queue the date it must produce.
    function void note_input(cct_item_t it);
      cct_result_t r;
      if (it.op == OP_LOAD) begin
        set_time(it);
        loads++;
      end else begin
        next_second();
        ticks++;
      end
      r.cur_month   = now.month;
      r.cur_day     = now.day;
      r.cur_year    = now.year;
      r.cur_hour    = now.hour;
      r.cur_minute  = now.minute;
      r.cur_second  = now.second;
      r.hour_twelve = (now.hour == 5'd0 || now.hour == HOUR_NOON) ?
                      HOUR_TWELVE : 4'(now.hour % HOUR_NOON);
      r.is_pm       = (now.hour >= HOUR_NOON);
      owed_dates.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(cct_result_t got);
      cct_result_t want;
      if (owed_dates.size() == 0) begin
        $error("result item arrived with no date expected");
        mismatches++;
        return;
      end
      want = owed_dates.pop_front();
      compare_field("cur_month", want.cur_month, got.cur_month);
      compare_field("cur_day", want.cur_day, got.cur_day);
      compare_field("cur_year", want.cur_year, got.cur_year);
      compare_field("cur_hour", want.cur_hour, got.cur_hour);
      compare_field("cur_minute", want.cur_minute, got.cur_minute);
      compare_field("cur_second", want.cur_second, got.cur_second);
      compare_field("hour_twelve", want.hour_twelve, got.hour_twelve);
      compare_field("is_pm", want.is_pm, got.is_pm);
    endfunction

    function int unsigned pending();
      return owed_dates.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cct_in_if  in_ch ();
  cct_out_if out_ch ();

  calendar_clock_tick dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  date_time_tracker tracker = new();

  int unsigned sent_items;
  int unsigned taken_results;
  bit          in_calm;
  bit          out_calm;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic cct_item_t make_load(int unsigned m, int unsigned d, int unsigned y,
                                          int unsigned h, int unsigned mi, int unsigned s);
    cct_item_t it;
    it.op          = OP_LOAD;
    it.load_month  = 4'(m);
    it.load_day    = 5'(d);
    it.load_year   = 14'(y);
    it.load_hour   = 5'(h);
    it.load_minute = 6'(mi);
    it.load_second = 6'(s);
    return it;
  endfunction

  // Any bits in every field; the op is chosen by the caller.
  function automatic cct_item_t make_noise(logic op);
    cct_item_t it;
    it = make_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.op = op;
    return it;
  endfunction

  // A date and time, not always valid, a few seconds short of a carry, often at the end of
  // a month or year and often in a leap-rule year.
  function automatic cct_item_t make_near_rollover();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned len;
    case ($urandom_range(0, 7))
      0: y = YEAR_MIN;
      1: y = 2100;
      2: y = 2400;
      3: y = YEAR_MAX;
      4: y = 4 * $urandom_range(500, 2499);
      5: y = $urandom_range(0, 16383);
      default: y = $urandom_range(YEAR_MIN, YEAR_MAX);
    endcase
    m = ($urandom_range(0, 3) == 0) ? 2 : (($urandom_range(0, 2) == 0) ? 12 :
        $urandom_range(1, 12));
    len = date_time_tracker::month_length(m, (y < YEAR_MIN) ? YEAR_MIN :
                                             (y > YEAR_MAX) ? YEAR_MAX : y);
    case ($urandom_range(0, 3))
      0: d = len;
      1: d = len - 1;
      2: d = 29;
      default: d = $urandom_range(1, len);
    endcase
    return make_load(m, d, y,
                     ($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23),
                     ($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59),
                     $urandom_range(55, 59));
  endfunction

  // Offer one item after a random gap and wait for it to be taken.
  task automatic drive_item(cct_item_t it);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_input(it);
    sent_items++;
    if (sent_items % CALM_PERIOD == 0) in_calm = ($urandom_range(0, 3) == 0);
    @(negedge clk_i);
  endtask

  task automatic drive_ticks(int unsigned n);
    repeat (n) drive_item(make_noise(OP_TICK));
  endtask

  // Clamping, leap days, month and year carries and the year limit.
  task automatic run_directed();
    drive_ticks(1);
    drive_item(make_load(2, 29, 2000, 23, 59, 59));
    drive_ticks(1);
    drive_item(make_load(2, 29, 2100, 12, 0, 0));
    drive_item(make_load(2, 29, 2400, 11, 59, 59));
    drive_ticks(1);
    drive_item(make_load(2, 28, 2024, 23, 59, 59));
    drive_ticks(1);
    drive_item(make_load(2, 28, 2023, 23, 59, 59));
    drive_ticks(1);
    drive_item(make_load(12, 31, 9999, 23, 59, 59));
    drive_ticks(1);
    drive_item(make_load(12, 31, 2099, 23, 59, 59));
    drive_ticks(1);
    drive_item(make_load(0, 0, 0, 24, 60, 60));
    drive_item(make_load(15, 31, 16383, 31, 63, 63));
    drive_item(make_load(13, 31, 1999, 0, 0, 0));
    drive_item(make_load(4, 31, 2001, 12, 59, 59));
    drive_ticks(1);
    drive_item(make_load(6, 30, 5000, 23, 59, 59));
    drive_ticks(1);
    drive_item(make_load(1, 1, 9999, 1, 2, 3));
    // A tick ignores whatever sits in the load fields.
    drive_item(make_load(15, 31, 16383, 31, 63, 63) & ~cct_item_t'({1'b1, 40'b0}));
  endtask

  // Mostly near-rollover loads followed by ticks across the carry, with some
  // long tick runs and some raw noise items.
  task automatic run_random(int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = sent_items;
    while (sent_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        drive_item(make_noise(1'($urandom)));
      end else if (pick < 15) begin
        drive_item(make_load($urandom_range(1, 12), $urandom_range(1, 28),
                             $urandom_range(YEAR_MIN, YEAR_MAX), $urandom_range(0, 23),
                             $urandom_range(0, 59), $urandom_range(0, 59)));
        drive_ticks($urandom_range(61, 130));
      end else begin
        drive_item(make_near_rollover());
        drive_ticks($urandom_range(1, 8));
      end
    end
  endtask

  // Result side: random stalls, every result checked in order.
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    out_calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      tracker.check_result(out_ch.data);
      taken_results++;
      if (taken_results % CALM_PERIOD == 0) out_calm = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no item moved for %0d cycles, %0d dates still owed",
           STALL_LIMIT, tracker.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    in_calm     = 1'b0;
    sent_items  = 0;
    taken_results = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random(RANDOM_ITEMS);
    in_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d items (%0d loads, %0d of them repaired, %0d ticks).",
             sent_items, tracker.loads, tracker.fixed_loads, tracker.ticks);
    $display("Carries seen: %0d month, %0d year, %0d leap days, %0d holds at year end.",
             tracker.month_rolls, tracker.year_rolls, tracker.leap_days,
             tracker.year_holds);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
